// ===== rtl/lhwfb_pkg.sv =====
// ----------------------------------------------------------------------------
// lhwfb_pkg: shared types, constants and the hue wheel color function
// Register indexes, request codes, sequencer states and reset values used by
// the frame buffer.
// ----------------------------------------------------------------------------
package lhwfb_pkg;

  localparam int unsigned LedCountDef = 4;

  localparam logic [7:0] HueSpacingRst   = 8'd35;
  localparam logic [7:0] PhaseAdvanceRst = 8'd2;
  localparam logic [2:0] BrightShiftRst  = 3'd1;

  // Hue wheel: six regions of 43 hue steps each, the last holding 41
  localparam logic [7:0] RegionSize = 8'd43;
  localparam logic [7:0] ChanFull   = 8'hFF;

  // One stored row per LED: green, red, blue
  localparam int unsigned RowW = 24;

  typedef enum logic [1:0] {
    CFG_HUE_SPACING   = 2'd0,
    CFG_PHASE_ADVANCE = 2'd1,
    CFG_BRIGHT_SHIFT  = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_SET_RGB = 2'd0,
    REQ_SET_HUE = 2'd1,
    REQ_WAVE    = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUE_DIV,
    ST_HUE_WR,
    ST_RD_REQ,
    ST_RD_BYTE
  } state_e;

  typedef struct packed {
    logic [7:0] grn;
    logic [7:0] red;
    logic [7:0] blu;
  } pixel_t;

  // region: quotient hue / 43, offset: remainder (below 43), sh: brightness shift
  function automatic pixel_t hue_color(input logic [2:0] region,
                                       input logic [5:0] offset,
                                       input logic [2:0] sh);
    logic [7:0] rem;
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    pixel_t     px;
    rem  = 8'({2'b00, offset} * 8'd6);
    // 255 * x >> 8 equals x - 1 for 1 <= x <= 255
    up   = (rem == 8'd0) ? 8'd0 : rem - 8'd1;
    down = 8'd254 - rem;
    case (region)
      3'd0: begin r = ChanFull; g = up;       b = 8'd0;     end
      3'd1: begin r = down;     g = ChanFull; b = 8'd0;     end
      3'd2: begin r = 8'd0;     g = ChanFull; b = up;       end
      3'd3: begin r = 8'd0;     g = down;     b = ChanFull; end
      3'd4: begin r = up;       g = 8'd0;     b = ChanFull; end
      default: begin r = ChanFull; g = 8'd0;  b = down;     end
    endcase
    px.red = r >> sh;
    px.grn = g >> sh;
    px.blu = b >> sh;
    return px;
  endfunction

endpackage

// ===== rtl/lhwfb_ram.sv =====
// ----------------------------------------------------------------------------
// lhwfb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lhwfb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/led_hue_wheel_frame_buffer.sv =====
// ----------------------------------------------------------------------------
// led_hue_wheel_frame_buffer: pixel store with hue wheel and wave animation
// Holds green, red, blue bytes per LED and an 8-bit animation phase.
// ----------------------------------------------------------------------------
// Requests arrive one beat at a time on the input channel and are handled one
// at a time; in_stall_o stays high until the sequencer is back in idle. A set
// pixel RGB request is written straight from the accepting beat. After the
// accepting cycle, a set pixel hue request runs the shared compare-subtract
// unit once per 43-step wheel region plus one final compare and then writes
// the row. A wave step does the same for every LED in turn and then adds the
// phase advance. A frame read-out issues one row read per LED from the row
// RAM (registered read) and then emits green, red and blue as three output
// beats. The output beat sits in a register, so the next request is taken
// while the last byte still waits.
// Requests for an LED index at or past LED_COUNT change nothing. The store
// reads as zero after reset through per-LED valid flops; there is no clearing
// pass. byte_position wraps modulo 16. Configuration (index 0 hue spacing,
// 1 phase advance, 2 brightness shift) is always ready and must only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module led_hue_wheel_frame_buffer #(
  parameter int unsigned LED_COUNT = lhwfb_pkg::LedCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [2:0] led_index_i,
  input  logic [7:0] red_level_i,
  input  logic [7:0] green_level_i,
  input  logic [7:0] blue_level_i,
  input  logic [7:0] hue_value_i,
  // frame byte channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic [3:0] byte_position_o,
  output logic       last_byte_o
);

  import lhwfb_pkg::*;

  localparam int unsigned IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IdxW-1:0] LastRow = IdxW'(LED_COUNT - 1);

  // --- configuration registers ---
  logic [7:0] hue_spacing_q;
  logic [7:0] phase_advance_q;
  logic [2:0] bright_shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_spacing_q   <= HueSpacingRst;
      phase_advance_q <= PhaseAdvanceRst;
      bright_shift_q  <= BrightShiftRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HUE_SPACING:   hue_spacing_q   <= cfg_data_i;
        CFG_PHASE_ADVANCE: phase_advance_q <= cfg_data_i;
        CFG_BRIGHT_SHIFT:  bright_shift_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // --- sequencer state ---
  state_e          state_q, state_d;
  logic            wave_q, wave_d;         // wave step in progress
  logic            in_range_q, in_range_d; // target LED exists
  logic [IdxW-1:0] row_q, row_d;           // LED being converted or read
  logic [7:0]      work_q, work_d;         // hue, reduced by 43 per step
  logic [2:0]      region_q, region_d;
  logic [7:0]      hue_acc_q, hue_acc_d;   // wave hue of current LED
  logic [7:0]      phase_q, phase_d;
  logic [1:0]      byte_sel_q, byte_sel_d;
  logic [3:0]      pos_q, pos_d;
  logic            rd_vld_q, rd_vld_d;     // row valid captured with the read
  logic [LED_COUNT-1:0] row_vld_q, row_vld_d;

  // --- output register ---
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [3:0] out_pos_q, out_pos_d;
  logic       out_last_q, out_last_d;

  // --- RAM port signals ---
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  pixel_t          wr_px;
  logic            rd_en;
  pixel_t          rd_px;
  logic [RowW-1:0] rd_data;

  logic            in_acc;
  logic [6:0]      idx_ext;
  logic            idx_ok;
  pixel_t          hue_px;
  logic            out_free;
  logic [7:0]      sel_byte;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign idx_ext  = {4'b0000, led_index_i};
  assign idx_ok   = idx_ext < 7'(LED_COUNT);
  assign hue_px   = hue_color(region_q, work_q[5:0], bright_shift_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_px    = pixel_t'(rd_data);

  always_comb begin
    case (byte_sel_q)
      2'd0:    sel_byte = rd_px.grn;
      2'd1:    sel_byte = rd_px.red;
      default: sel_byte = rd_px.blu;
    endcase
    if (!rd_vld_q) begin
      sel_byte = 8'd0;
    end
  end

  always_comb begin
    state_d     = state_q;
    wave_d      = wave_q;
    in_range_d  = in_range_q;
    row_d       = row_q;
    work_d      = work_q;
    region_d    = region_q;
    hue_acc_d   = hue_acc_q;
    phase_d     = phase_q;
    byte_sel_d  = byte_sel_q;
    pos_d       = pos_q;
    rd_vld_d    = rd_vld_q;
    row_vld_d   = row_vld_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    wr_en       = 1'b0;
    wr_addr     = row_q;
    wr_px       = hue_px;
    rd_en       = 1'b0;
    in_stall_o  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          case (req_e'(req_type_i))
            REQ_SET_RGB: begin
              // written straight from the beat
              wr_en       = idx_ok;
              wr_addr     = idx_ext[IdxW-1:0];
              wr_px.grn   = green_level_i;
              wr_px.red   = red_level_i;
              wr_px.blu   = blue_level_i;
              if (idx_ok) begin
                row_vld_d[idx_ext[IdxW-1:0]] = 1'b1;
              end
            end
            REQ_SET_HUE: begin
              wave_d     = 1'b0;
              in_range_d = idx_ok;
              row_d      = idx_ext[IdxW-1:0];
              work_d     = hue_value_i;
              region_d   = 3'd0;
              state_d    = ST_HUE_DIV;
            end
            REQ_WAVE: begin
              wave_d     = 1'b1;
              in_range_d = 1'b1;
              row_d      = '0;
              work_d     = phase_q;
              hue_acc_d  = phase_q;
              region_d   = 3'd0;
              state_d    = ST_HUE_DIV;
            end
            default: begin
              row_d      = '0;
              byte_sel_d = 2'd0;
              pos_d      = 4'd0;
              state_d    = ST_RD_REQ;
            end
          endcase
        end
      end

      ST_HUE_DIV: begin
        // shared compare-subtract: one wheel region per cycle
        if (work_q >= RegionSize) begin
          work_d   = work_q - RegionSize;
          region_d = region_q + 3'd1;
        end else begin
          state_d = ST_HUE_WR;
        end
      end

      ST_HUE_WR: begin
        wr_en = in_range_q;
        if (in_range_q) begin
          row_vld_d[row_q] = 1'b1;
        end
        if (wave_q && (row_q != LastRow)) begin
          row_d     = row_q + IdxW'(1);
          hue_acc_d = hue_acc_q + hue_spacing_q;
          work_d    = hue_acc_q + hue_spacing_q;
          region_d  = 3'd0;
          state_d   = ST_HUE_DIV;
        end else begin
          if (wave_q) begin
            phase_d = phase_q + phase_advance_q;
          end
          state_d = ST_IDLE;
        end
      end

      ST_RD_REQ: begin
        rd_en      = 1'b1;
        rd_vld_d   = row_vld_q[row_q];
        byte_sel_d = 2'd0;
        state_d    = ST_RD_BYTE;
      end

      ST_RD_BYTE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = sel_byte;
          out_pos_d   = pos_q;
          out_last_d  = (row_q == LastRow) && (byte_sel_q == 2'd2);
          pos_d       = pos_q + 4'd1;
          if (byte_sel_q == 2'd2) begin
            if (row_q == LastRow) begin
              state_d = ST_IDLE;
            end else begin
              row_d   = row_q + IdxW'(1);
              state_d = ST_RD_REQ;
            end
          end else begin
            byte_sel_d = byte_sel_q + 2'd1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wave_q      <= 1'b0;
      in_range_q  <= 1'b0;
      row_q       <= '0;
      phase_q     <= 8'd0;
      byte_sel_q  <= 2'd0;
      pos_q       <= 4'd0;
      rd_vld_q    <= 1'b0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wave_q      <= wave_d;
      in_range_q  <= in_range_d;
      row_q       <= row_d;
      phase_q     <= phase_d;
      byte_sel_q  <= byte_sel_d;
      pos_q       <= pos_d;
      rd_vld_q    <= rd_vld_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    region_q   <= region_d;
    hue_acc_q  <= hue_acc_d;
    out_byte_q <= out_byte_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
  end

  lhwfb_ram #(
    .Width (RowW),
    .Depth (LED_COUNT)
  ) u_row_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (RowW'(wr_px)),
    .rd_en_i   (rd_en),
    .rd_addr_i (row_q),
    .rd_data_o (rd_data)
  );

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = out_byte_q;
  assign byte_position_o = out_pos_q;
  assign last_byte_o     = out_last_q;

endmodule
